>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers shared by the shortest-path core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, masked while reset is high.
`define SPD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that an expression never holds.
`define SPD_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   `SPD_ASSERT(lbl, clk, rst, !(expr), msg)

`endif

>>> rtl/core/spd_pkg.sv
// ----------------------------------------------------------------------------
// spd_pkg
// Shared types and constants of the shortest-path core.
// ----------------------------------------------------------------------------
package spd_pkg;

   localparam int NODE_FIELD_BITS = 6;
   localparam int COST_FIELD_BITS = 16;
   localparam int DIST_BITS       = 22;
   localparam int RESULT_CAP      = 64;
   localparam int K_BITS          = 6;

   typedef logic [DIST_BITS-1:0] dist_type;

   localparam dist_type DIST_MAX = {DIST_BITS{1'b1}};

   localparam logic OP_ADD_EDGE = 1'b0;
   localparam logic OP_QUERY    = 1'b1;

   // outcome of one relaxation step
   typedef struct packed {
      logic     upd;       // write the new distance and predecessor
      logic     elig;      // node is a candidate for the next round
      dist_type new_dist;  // distance after the step
   } relax_res_type;

endpackage

>>> rtl/core/spd_ram.sv
// ----------------------------------------------------------------------------
// spd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module spd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/spd_relax.sv
// ----------------------------------------------------------------------------
// spd_relax
// Relaxation unit: saturating add of an edge weight and the distance compare.
// ----------------------------------------------------------------------------
module spd_relax #(
   parameter int WEIGHT_W = 16
) (
   input  spd_pkg::dist_type      pick_dist,
   input  logic [WEIGHT_W-1:0]    weight,
   input  logic                   present,
   input  logic                   settled,
   input  logic                   finite,
   input  spd_pkg::dist_type      cur_dist,
   output spd_pkg::relax_res_type res
);

   import spd_pkg::*;

   localparam int SumW = DIST_BITS + 1;

   logic [SumW-1:0] sum;
   dist_type        cand;
   logic            upd;

   assign sum  = {1'b0, pick_dist} + SumW'(weight);
   // saturate at the largest distance
   assign cand = sum[DIST_BITS] ? DIST_MAX : sum[DIST_BITS-1:0];
   assign upd  = !settled && present && (!finite || (cur_dist > cand));

   always_comb begin
      res.upd      = upd;
      res.elig     = !settled && (finite || upd);
      res.new_dist = upd ? cand : cur_dist;
   end

endmodule

>>> rtl/core/shortest_path_dijkstra.sv
// ----------------------------------------------------------------------------
// shortest_path_dijkstra
// Adjacency-matrix graph store with a Dijkstra search and path readout.
// ----------------------------------------------------------------------------
//   channel  dir  handshake            payload
//   req_*    in   req_valid/req_stall  op, node_a, node_b, edge_cost,
//                                      source_node, target_node
//   rsp_*    out  rsp_valid/rsp_stall  path_node, path_last, no_path, path_cost
//
// After reset a clearing pass wipes the matrix presence bits, one entry a
// cycle, all 2**(2*clog2(NODE_COUNT)) entries (4096 at 64 nodes); no request
// is taken meanwhile. An add-edge request writes one direction, then the
// other, through the single matrix write port. A query sweeps one matrix row
// a round through the single relaxation unit, one round per settled node,
// then reads the path out node by node. A stalled result holds in the output
// register; the next request is taken once the last result is loaded.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module shortest_path_dijkstra #(
   parameter int NODE_COUNT  = 64,
   parameter int WEIGHT_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_op,
   input  logic [spd_pkg::NODE_FIELD_BITS-1:0]  req_node_a,
   input  logic [spd_pkg::NODE_FIELD_BITS-1:0]  req_node_b,
   input  logic [spd_pkg::COST_FIELD_BITS-1:0]  req_edge_cost,
   input  logic [spd_pkg::NODE_FIELD_BITS-1:0]  req_source_node,
   input  logic [spd_pkg::NODE_FIELD_BITS-1:0]  req_target_node,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [spd_pkg::NODE_FIELD_BITS-1:0]  rsp_path_node,
   output logic                                 rsp_path_last,
   output logic                                 rsp_no_path,
   output logic [spd_pkg::DIST_BITS-1:0]        rsp_path_cost
);

   import spd_pkg::*;

   localparam int NB     = $clog2(NODE_COUNT);
   localparam int CW     = NB + 1;
   localparam int MAT_AW = 2 * NB;
   localparam int WB     = (WEIGHT_BITS < COST_FIELD_BITS) ? WEIGHT_BITS : COST_FIELD_BITS;

   localparam logic [K_BITS-1:0] K_LAST = K_BITS'(RESULT_CAP - 1);
   localparam logic [CW-1:0]     CNT_END = CW'(NODE_COUNT);

   localparam logic [3:0] ST_CLEAR  = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_EDGE2  = 4'd2;
   localparam logic [3:0] ST_RELAX  = 4'd3;
   localparam logic [3:0] ST_COST   = 4'd4;
   localparam logic [3:0] ST_COST2  = 4'd5;
   localparam logic [3:0] ST_EMIT   = 4'd6;
   localparam logic [3:0] ST_NEXT   = 4'd7;
   localparam logic [3:0] ST_NOPATH = 4'd8;

   // control
   logic [3:0]            state_ff,     state_in;
   logic [MAT_AW-1:0]     clr_ff,       clr_in;
   logic [CW-1:0]         issue_cnt_ff, issue_cnt_in;
   logic                  s1_valid_ff,  s1_valid_in;
   logic                  s2_valid_ff,  s2_valid_in;
   logic                  min_found_ff, min_found_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // payload
   logic [NODE_COUNT-1:0] settled_ff,   settled_in;
   logic [NODE_COUNT-1:0] finite_ff,    finite_in;
   logic [NB-1:0]         edge_a_ff,    edge_a_in;
   logic [NB-1:0]         edge_b_ff,    edge_b_in;
   logic [WB-1:0]         weight_ff,    weight_in;
   logic [NB-1:0]         src_idx_ff,   src_idx_in;
   logic [NB-1:0]         dst_idx_ff,   dst_idx_in;
   logic [NODE_FIELD_BITS-1:0] target_ff, target_in;
   logic [NB-1:0]         pick_ff,      pick_in;
   dist_type              pick_dist_ff, pick_dist_in;
   logic [NB-1:0]         s1_idx_ff,    s1_idx_in;
   logic                  s2_elig_ff,   s2_elig_in;
   dist_type              s2_dist_ff,   s2_dist_in;
   logic [NB-1:0]         s2_idx_ff,    s2_idx_in;
   logic [NB-1:0]         min_idx_ff,   min_idx_in;
   dist_type              min_dist_ff,  min_dist_in;
   dist_type              cost_ff,      cost_in;
   logic [NB-1:0]         cur_ff,       cur_in;
   logic [K_BITS-1:0]     k_ff,         k_in;
   logic [NODE_FIELD_BITS-1:0] out_node_ff, out_node_in;
   logic                  out_last_ff,  out_last_in;
   logic                  out_nopath_ff, out_nopath_in;
   dist_type              out_cost_ff,  out_cost_in;

   // memories
   logic                  mat_we;
   logic [MAT_AW-1:0]     mat_waddr;
   logic [WB:0]           mat_wdata;
   logic [MAT_AW-1:0]     mat_raddr;
   logic [WB:0]           mat_rdata;
   logic                  dist_we;
   logic [NB-1:0]         dist_waddr;
   dist_type              dist_wdata;
   logic [NB-1:0]         dist_raddr;
   dist_type              dist_rdata;
   logic                  pred_we;
   logic [NB-1:0]         pred_rdata;

   logic                  req_acc;
   logic                  out_free;
   logic                  src_ok;
   logic                  dst_ok;
   logic                  a_ok;
   logic                  b_ok;
   logic                  path_last;
   logic [NB-1:0]         req_a_idx;
   logic [NB-1:0]         req_b_idx;
   logic [NB-1:0]         req_src_idx;
   logic [NB-1:0]         issue_idx;
   relax_res_type         rr;

   assign req_stall   = (state_ff != ST_IDLE);
   assign req_acc     = req_valid && !req_stall;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign src_ok      = 32'(req_source_node) < NODE_COUNT;
   assign dst_ok      = 32'(req_target_node) < NODE_COUNT;
   assign a_ok        = 32'(req_node_a) < NODE_COUNT;
   assign b_ok        = 32'(req_node_b) < NODE_COUNT;
   assign req_a_idx   = NB'(req_node_a);
   assign req_b_idx   = NB'(req_node_b);
   assign req_src_idx = NB'(req_source_node);
   assign issue_idx   = issue_cnt_ff[NB-1:0];
   assign path_last   = (cur_ff == src_idx_ff) || (k_ff == K_LAST);

   assign mat_raddr   = {pick_ff, issue_idx};
   assign dist_raddr  = (state_ff == ST_RELAX) ? issue_idx : dst_idx_ff;
   assign pred_we     = s1_valid_ff && rr.upd;

   spd_ram #(.WIDTH(WB + 1), .DEPTH(1 << MAT_AW)) u_matrix (
      .clock   (clock),
      .wr_en   (mat_we),
      .wr_addr (mat_waddr),
      .wr_data (mat_wdata),
      .rd_addr (mat_raddr),
      .rd_data (mat_rdata)
   );

   spd_ram #(.WIDTH(DIST_BITS), .DEPTH(1 << NB)) u_dist (
      .clock   (clock),
      .wr_en   (dist_we),
      .wr_addr (dist_waddr),
      .wr_data (dist_wdata),
      .rd_addr (dist_raddr),
      .rd_data (dist_rdata)
   );

   spd_ram #(.WIDTH(NB), .DEPTH(1 << NB)) u_pred (
      .clock   (clock),
      .wr_en   (pred_we),
      .wr_addr (s1_idx_ff),
      .wr_data (pick_ff),
      .rd_addr (cur_ff),
      .rd_data (pred_rdata)
   );

   spd_relax #(.WEIGHT_W(WB)) u_relax (
      .pick_dist (pick_dist_ff),
      .weight    (mat_rdata[WB-1:0]),
      .present   (mat_rdata[WB]),
      .settled   (settled_ff[s1_idx_ff]),
      .finite    (finite_ff[s1_idx_ff]),
      .cur_dist  (dist_rdata),
      .res       (rr)
   );

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      issue_cnt_in  = issue_cnt_ff;
      s1_valid_in   = 1'b0;
      s1_idx_in     = issue_idx;
      min_found_in  = min_found_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      settled_in    = settled_ff;
      finite_in     = finite_ff;
      edge_a_in     = edge_a_ff;
      edge_b_in     = edge_b_ff;
      weight_in     = weight_ff;
      src_idx_in    = src_idx_ff;
      dst_idx_in    = dst_idx_ff;
      target_in     = target_ff;
      pick_in       = pick_ff;
      pick_dist_in  = pick_dist_ff;
      min_idx_in    = min_idx_ff;
      min_dist_in   = min_dist_ff;
      cost_in       = cost_ff;
      cur_in        = cur_ff;
      k_in          = k_ff;
      out_node_in   = out_node_ff;
      out_last_in   = out_last_ff;
      out_nopath_in = out_nopath_ff;
      out_cost_in   = out_cost_ff;
      mat_we        = 1'b0;
      mat_waddr     = {req_a_idx, req_b_idx};
      mat_wdata     = {1'b1, WB'(req_edge_cost)};
      dist_we       = 1'b0;
      dist_waddr    = s1_idx_ff;
      dist_wdata    = rr.new_dist;

      // relaxation stage: data of the entry issued last cycle
      s2_valid_in = s1_valid_ff;
      s2_elig_in  = rr.elig;
      s2_dist_in  = rr.new_dist;
      s2_idx_in   = s1_idx_ff;
      if (s1_valid_ff && rr.upd) begin
         dist_we              = 1'b1;
         finite_in[s1_idx_ff] = 1'b1;
      end

      // minimum tracking stage: ascending order keeps the lowest index on ties
      if (s2_valid_ff && s2_elig_ff && (!min_found_ff || (s2_dist_ff < min_dist_ff))) begin
         min_found_in = 1'b1;
         min_idx_in   = s2_idx_ff;
         min_dist_in  = s2_dist_ff;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mat_we    = 1'b1;
            mat_waddr = clr_ff;
            mat_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_acc) begin
               priority if (req_op == OP_ADD_EDGE) begin
                  if ((req_node_a != req_node_b) && a_ok && b_ok) begin
                     mat_we    = 1'b1;
                     edge_a_in = req_a_idx;
                     edge_b_in = req_b_idx;
                     weight_in = WB'(req_edge_cost);
                     state_in  = ST_EDGE2;
                  end
               end else if (src_ok && dst_ok) begin
                  // seed the search with the source as the first pick
                  dist_we                  = 1'b1;
                  dist_waddr               = req_src_idx;
                  dist_wdata               = '0;
                  settled_in               = '0;
                  settled_in[req_src_idx]  = 1'b1;
                  finite_in                = '0;
                  finite_in[req_src_idx]   = 1'b1;
                  src_idx_in               = req_src_idx;
                  dst_idx_in               = NB'(req_target_node);
                  target_in                = req_target_node;
                  pick_in                  = req_src_idx;
                  pick_dist_in             = '0;
                  issue_cnt_in             = '0;
                  min_found_in             = 1'b0;
                  state_in                 = ST_RELAX;
               end else begin
                  target_in = req_target_node;
                  state_in  = ST_NOPATH;
               end
            end
         end
         ST_EDGE2: begin
            mat_we    = 1'b1;
            mat_waddr = {edge_b_ff, edge_a_ff};
            mat_wdata = {1'b1, weight_ff};
            state_in  = ST_IDLE;
         end
         ST_RELAX: begin
            priority if (issue_cnt_ff != CNT_END) begin
               s1_valid_in  = 1'b1;
               issue_cnt_in = issue_cnt_ff + 1'b1;
            end else if (!s1_valid_ff && !s2_valid_ff) begin
               if (min_found_ff) begin
                  // settle the nearest open node and sweep its row
                  pick_in                = min_idx_ff;
                  pick_dist_in           = min_dist_ff;
                  settled_in[min_idx_ff] = 1'b1;
                  issue_cnt_in           = '0;
                  min_found_in           = 1'b0;
               end else if (finite_ff[dst_idx_ff]) begin
                  state_in = ST_COST;
               end else begin
                  state_in = ST_NOPATH;
               end
            end else begin
               // hold until the relax pipeline drains
               state_in = ST_RELAX;
            end
         end
         ST_COST: begin
            state_in = ST_COST2;
         end
         ST_COST2: begin
            cost_in  = dist_rdata;
            cur_in   = dst_idx_ff;
            k_in     = '0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               out_node_in   = NODE_FIELD_BITS'(cur_ff);
               out_last_in   = path_last;
               out_nopath_in = 1'b0;
               out_cost_in   = cost_ff;
               k_in          = k_ff + 1'b1;
               state_in      = path_last ? ST_IDLE : ST_NEXT;
            end
         end
         ST_NEXT: begin
            cur_in   = pred_rdata;
            state_in = ST_EMIT;
         end
         ST_NOPATH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               out_node_in   = target_ff;
               out_last_in   = 1'b1;
               out_nopath_in = 1'b1;
               out_cost_in   = '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         issue_cnt_ff <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         min_found_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         issue_cnt_ff <= issue_cnt_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         min_found_ff <= min_found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      settled_ff    <= settled_in;
      finite_ff     <= finite_in;
      edge_a_ff     <= edge_a_in;
      edge_b_ff     <= edge_b_in;
      weight_ff     <= weight_in;
      src_idx_ff    <= src_idx_in;
      dst_idx_ff    <= dst_idx_in;
      target_ff     <= target_in;
      pick_ff       <= pick_in;
      pick_dist_ff  <= pick_dist_in;
      s1_idx_ff     <= s1_idx_in;
      s2_elig_ff    <= s2_elig_in;
      s2_dist_ff    <= s2_dist_in;
      s2_idx_ff     <= s2_idx_in;
      min_idx_ff    <= min_idx_in;
      min_dist_ff   <= min_dist_in;
      cost_ff       <= cost_in;
      cur_ff        <= cur_in;
      k_ff          <= k_in;
      out_node_ff   <= out_node_in;
      out_last_ff   <= out_last_in;
      out_nopath_ff <= out_nopath_in;
      out_cost_ff   <= out_cost_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_path_node = out_node_ff;
   assign rsp_path_last = out_last_ff;
   assign rsp_no_path   = out_nopath_ff;
   assign rsp_path_cost = out_cost_ff;

   `SPD_ASSERT(a_nopath_is_last, clock, reset, rsp_valid && rsp_no_path |-> rsp_path_last, "no-path response without path_last")
   `SPD_ASSERT(a_pick_settled, clock, reset, state_ff == ST_RELAX |-> settled_ff[pick_ff], "row swept for an unsettled node")
   `SPD_ASSERT(a_update_finite, clock, reset, s1_valid_ff && rr.upd |=> finite_ff[$past(s1_idx_ff)], "relaxed node not marked reachable")
   `SPD_ASSERT_NEVER(a_pipe_outside_search, clock, reset, s2_valid_ff && (state_ff != ST_RELAX), "relax pipeline busy outside search")

endmodule
